[rtl/core/parabolic_sine_cosine_core_defines.svh]
// Assertion macros for the parabolic sine/cosine core.
// Used by the pipeline control; no other dependencies.
`ifndef PARABOLIC_SINE_COSINE_CORE_DEFINES_SVH
`define PARABOLIC_SINE_COSINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pipeline check failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define PSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pipeline check failed (next cycle)");

`endif

[rtl/core/psc_pkg.sv]
// Shared types and constants for the parabolic sine/cosine core.
// No dependencies.
`default_nettype none

package psc_pkg;

	localparam int ANGLE_W = 18;
	localparam int VALUE_W = 16;
	localparam int WORK_BITS = 24;

	localparam int DEF_ANGLE_FRAC_BITS = 13;
	localparam int DEF_RESULT_FRAC_BITS = 15;

	// Function select
	localparam logic OP_SINE = 1'b0;
	localparam logic OP_COSINE = 1'b1;

	// Q.24 constants, round to nearest (K_PI rounded down)
	localparam logic signed [27:0] K_HALF_PI = 28'sd26353589;
	localparam logic signed [27:0] K_PI = 28'sd52707178;
	localparam logic signed [27:0] K_TWO_PI = 28'sd105414357;
	localparam logic signed [25:0] K_FOUR_OVER_PI = 26'sd21361415;
	localparam logic signed [23:0] K_FOUR_OVER_PI_SQ = 24'sd6799550;
	localparam logic signed [22:0] K_REFINE = 23'sd3774874;

	// Datapath widths after clamping
	localparam int XW = 29;  // angle, +-8 rad
	localparam int YW = 27;  // parabola, +-2.0
	localparam int ZW = 28;  // y*|y|
	localparam int DW = 29;  // z - y
	localparam int FW = 30;  // refined value

	localparam logic signed [XW-1:0] X_LIMIT = 29'sd134217728;
	localparam logic signed [32:0] Y_LIMIT = 33'sd33554432;

	localparam int NUM_STAGES = 12;

	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
		logic [NUM_STAGES-1:0] valid;
	} pipe_ctl_t;

endpackage

`default_nettype wire

[rtl/core/psc_pipe_ctrl.sv]
// Valid tracking and per-stage load enables for the core pipeline.
// Depends on psc_pkg and parabolic_sine_cosine_core_defines.svh.
`default_nettype none
`include "parabolic_sine_cosine_core_defines.svh"

module psc_pipe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_ready,
	output psc_pkg::pipe_ctl_t ctl
);
	import psc_pkg::*;

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] load;
	logic                  in_fire;
	logic                  out_fire;

	// A stage may load when some stage at or after it has a hole,
	// or when the output request is being taken.
	always_comb begin
		for (int k = 0; k < NUM_STAGES; k++) begin
			load[k] = out_ready || (((~valid_q) >> k) != '0);
		end
	end

	assign in_ready = load[0];
	assign in_fire = in_valid && in_ready;
	assign out_fire = valid_q[NUM_STAGES-1] && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (load[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (load[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign ctl.load = load;
	assign ctl.valid = valid_q;

	`PSC_ASSERT_IMPLY(a_stall_only_when_full, clk, arst_n, !in_ready, (&valid_q) && !out_ready)
	`PSC_ASSERT_NEXT(a_count_hold, clk, arst_n, !in_fire && !out_fire, $countones(valid_q) == $past($countones(valid_q)))
	`PSC_ASSERT_NEXT(a_count_up, clk, arst_n, in_fire && !out_fire, $countones(valid_q) == $past($countones(valid_q)) + 1)
	`PSC_ASSERT_NEXT(a_count_down, clk, arst_n, out_fire && !in_fire, $countones(valid_q) == $past($countones(valid_q)) - 1)

endmodule

`default_nettype wire

[rtl/core/parabolic_sine_cosine_core.sv]
// Parabolic sine/cosine approximation, top level and datapath.
// Depends on psc_pkg and psc_pipe_ctrl.
//
// Usage:
//  - Input channel in_valid/in_ready carries opcode (0 sine, 1 cosine) and
//    a signed angle in radians with ANGLE_FRAC_BITS fraction bits.
//  - Output channel out_valid/out_ready carries value, signed with
//    RESULT_FRAC_BITS fraction bits, saturated at +32767 near +1.0.
//  - One request per cycle is accepted while in_ready is high; each gives
//    exactly one result, in order, through the 12-stage datapath (two
//    multiply stages each for the parabola and the refinement, rounding and
//    clamps between).
//  - Each stage has its own valid bit. When out_ready is low the last stage
//    holds; earlier stages keep filling until every stage is occupied, and
//    only then does in_ready drop. Nothing is dropped or duplicated.
//  - Reset (arst_n low) clears all valid bits; data registers are not reset.
//  - The block keeps no state between requests; one 2pi range correction
//    is applied, so angles beyond about +-3pi are outside the useful range.
`default_nettype none

module parabolic_sine_cosine_core #(
	parameter int ANGLE_FRAC_BITS = psc_pkg::DEF_ANGLE_FRAC_BITS,
	parameter int RESULT_FRAC_BITS = psc_pkg::DEF_RESULT_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic signed [psc_pkg::ANGLE_W-1:0]  angle,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [psc_pkg::VALUE_W-1:0]  value
);
	import psc_pkg::*;

	localparam int SA = WORK_BITS - ANGLE_FRAC_BITS;
	localparam int XRAW = ANGLE_W + SA;
	localparam int XRW = ((XRAW > XW) ? XRAW : XW) + 2;
	localparam int SH = WORK_BITS - RESULT_FRAC_BITS;

	localparam logic signed [XRW-1:0] HALF_PI_W = XRW'(K_HALF_PI);
	localparam logic signed [XRW-1:0] PI_W = XRW'(K_PI);
	localparam logic signed [XRW-1:0] TWO_PI_W = XRW'(K_TWO_PI);
	localparam logic signed [XRW-1:0] XLIM_W = XRW'(X_LIMIT);

	pipe_ctl_t ctl;

	psc_pipe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_ready(out_ready),
		.ctl      (ctl)
	);

	// ---- S1: scale to Q.24, cosine offset
	logic signed [XRW-1:0] x_scaled;
	logic signed [XRW-1:0] x0_s1;

	assign x_scaled = XRW'(angle) <<< SA;

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			x0_s1 <= x_scaled + ((opcode == OP_COSINE) ? HALF_PI_W : '0);
		end
	end

	// ---- S2: one 2pi correction, then clamp to +-8 rad
	logic signed [XRW-1:0] x_wrap;
	logic signed [XRW-1:0] x_clamp;
	logic signed [XW-1:0]  x_s2;

	always_comb begin
		if (x0_s1 < -PI_W) begin
			x_wrap = x0_s1 + TWO_PI_W;
		end else if (x0_s1 > PI_W) begin
			x_wrap = x0_s1 - TWO_PI_W;
		end else begin
			x_wrap = x0_s1;
		end
		if (x_wrap > XLIM_W) begin
			x_clamp = XLIM_W;
		end else if (x_wrap < -XLIM_W) begin
			x_clamp = -XLIM_W;
		end else begin
			x_clamp = x_wrap;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			x_s2 <= XW'(x_clamp);
		end
	end

	// ---- S3: x*|x| magnitude (= x*x) and (4/pi)*x
	logic signed [2*XW-1:0] sq_full;
	logic signed [XW+25:0]  kx_c;
	logic [54:0]            sq_s3;
	logic signed [XW+25:0]  kx_s3;
	logic                   neg_s3;

	assign sq_full = x_s2 * x_s2;
	assign kx_c = x_s2 * K_FOUR_OVER_PI;

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			sq_s3 <= sq_full[54:0];
			kx_s3 <= kx_c;
			neg_s3 <= x_s2[XW-1];
		end
	end

	// ---- S4: round p back to Q.24, restore sign
	logic [55:0]          p_sum;
	logic [31:0]          p_mag;
	logic signed [31:0]   p_s4;
	logic signed [XW+25:0] kx_s4;

	assign p_sum = {1'b0, sq_s3} + 56'd8388608;
	assign p_mag = p_sum[55:24];

	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			p_s4 <= neg_s3 ? (32'd0 - p_mag) : p_mag;
			kx_s4 <= kx_s3;
		end
	end

	// ---- S5: (4/pi^2)*p
	logic signed [55:0]    kp_c;
	logic signed [55:0]    kp_s5;
	logic signed [XW+25:0] kx_s5;

	assign kp_c = p_s4 * K_FOUR_OVER_PI_SQ;

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			kp_s5 <= kp_c;
			kx_s5 <= kx_s4;
		end
	end

	// ---- S6: y = round(kx - kp), clamp to +-2.0
	logic signed [56:0] y_diff;
	logic signed [56:0] y_sum;
	logic signed [32:0] y_rnd;
	logic signed [32:0] y_clamp;
	logic signed [YW-1:0] y_s6;

	assign y_diff = 57'(kx_s5) - 57'(kp_s5);
	// ties away from zero: subtract one ulp before the floor shift when negative
	assign y_sum = y_diff + 57'sd8388608 + {57{y_diff[56]}};
	assign y_rnd = y_sum[56:24];

	always_comb begin
		if (y_rnd > Y_LIMIT) begin
			y_clamp = Y_LIMIT;
		end else if (y_rnd < -Y_LIMIT) begin
			y_clamp = -Y_LIMIT;
		end else begin
			y_clamp = y_rnd;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			y_s6 <= YW'(y_clamp);
		end
	end

	// ---- S7: y*|y| magnitude
	logic signed [2*YW-1:0] sy_full;
	logic [50:0]            sy_s7;
	logic signed [YW-1:0]   y_s7;

	assign sy_full = y_s6 * y_s6;

	always_ff @(posedge clk) begin
		if (ctl.load[6]) begin
			sy_s7 <= sy_full[50:0];
			y_s7 <= y_s6;
		end
	end

	// ---- S8: z = round, signed like y
	logic [51:0]          z_sum;
	logic [ZW-1:0]        z_mag;
	logic signed [ZW-1:0] z_s8;
	logic signed [YW-1:0] y_s8;

	assign z_sum = {1'b0, sy_s7} + 52'd8388608;
	assign z_mag = z_sum[51:24];

	always_ff @(posedge clk) begin
		if (ctl.load[7]) begin
			z_s8 <= y_s7[YW-1] ? (ZW'(0) - z_mag) : z_mag;
			y_s8 <= y_s7;
		end
	end

	// ---- S9: d = z - y
	logic signed [DW-1:0] d_s9;
	logic signed [YW-1:0] y_s9;

	always_ff @(posedge clk) begin
		if (ctl.load[8]) begin
			d_s9 <= DW'(z_s8) - DW'(y_s8);
			y_s9 <= y_s8;
		end
	end

	// ---- S10: 0.225*d
	logic signed [DW+22:0] kr_c;
	logic signed [DW+22:0] kr_s10;
	logic signed [YW-1:0]  y_s10;

	assign kr_c = d_s9 * K_REFINE;

	always_ff @(posedge clk) begin
		if (ctl.load[9]) begin
			kr_s10 <= kr_c;
			y_s10 <= y_s9;
		end
	end

	// ---- S11: f = y + round(kr)
	logic signed [DW+22:0] kr_sum;
	logic signed [27:0]    kr_rnd;
	logic signed [FW-1:0]  f_s11;

	assign kr_sum = kr_s10 + (DW+23)'(8388608) + {(DW+23){kr_s10[DW+22]}};
	assign kr_rnd = kr_sum[DW+22:24];

	always_ff @(posedge clk) begin
		if (ctl.load[10]) begin
			f_s11 <= FW'(y_s10) + FW'(kr_rnd);
		end
	end

	// ---- S12: rescale to output fraction bits, saturate
	localparam logic signed [FW-1:0] VMAX = 30'sd32767;
	localparam logic signed [FW-1:0] VMIN = -30'sd32768;

	logic signed [FW-1:0]      f_sh;
	logic signed [FW-1:0]      f_sat;
	logic signed [VALUE_W-1:0] value_s12;

	if (SH > 0) begin : g_round
		localparam logic signed [FW-1:0] FRND = FW'(1) <<< (SH - 1);
		logic signed [FW-1:0] f_sum;
		assign f_sum = f_s11 + FRND + {FW{f_s11[FW-1]}};
		assign f_sh = f_sum >>> SH;
	end else begin : g_pass
		assign f_sh = f_s11;
	end

	always_comb begin
		if (f_sh > VMAX) begin
			f_sat = VMAX;
		end else if (f_sh < VMIN) begin
			f_sat = VMIN;
		end else begin
			f_sat = f_sh;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load[11]) begin
			value_s12 <= VALUE_W'(f_sat);
		end
	end

	assign value = value_s12;
	assign out_valid = ctl.valid[NUM_STAGES-1];

endmodule

`default_nettype wire

[test/parabolic_sine_cosine_core_tb.sv]
// Self-checking testbench for the parabolic sine/cosine core.
// Needs psc_pkg and the core RTL; a scoreboard class predicts each value
// from the accepted opcode and angle and checks results in order.
`timescale 1ns / 1ps

module parabolic_sine_cosine_core_tb;
	import psc_pkg::*;

	localparam int ANGLE_FRAC = DEF_ANGLE_FRAC_BITS;
	localparam int RESULT_FRAC = DEF_RESULT_FRAC_BITS;
	localparam int RANDOM_ITEMS = 2000;
	localparam int LONG_HOLD = 100;
	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 2 * NUM_STAGES;
	localparam int NUM_DIRECTED = 21;

	typedef struct {
		logic op;
		logic signed [ANGLE_W-1:0] ang;
		logic signed [VALUE_W-1:0] value;
	} sine_cosine_expect_t;

	class sine_cosine_scoreboard;
		sine_cosine_expect_t expected_q[$];
		int mismatches;
		int checked;
		int saturated;
		int sines;
		int cosines;

		// Divide by 2^s, round to nearest, ties away from zero
		function longint round_q(longint v, int s);
			longint m;
			m = (v < 0) ? -v : v;
			m = (m + (longint'(1) << (s - 1))) >>> s;
			return (v < 0) ? -m : m;
		endfunction

		function logic signed [VALUE_W-1:0] approx_value(logic op,
				logic signed [ANGLE_W-1:0] ang);
			longint k_half_pi, k_pi, k_two_pi, k_fop, k_fop_sq, k_refine;
			longint x_lim, y_lim;
			longint x, ax, p, y, ay, z, f, r;
			k_half_pi = longint'(K_HALF_PI);
			k_pi = longint'(K_PI);
			k_two_pi = longint'(K_TWO_PI);
			k_fop = longint'(K_FOUR_OVER_PI);
			k_fop_sq = longint'(K_FOUR_OVER_PI_SQ);
			k_refine = longint'(K_REFINE);
			x_lim = longint'(X_LIMIT);
			y_lim = longint'(Y_LIMIT);

			x = longint'(ang) * (longint'(1) << (WORK_BITS - ANGLE_FRAC));
			if (op == OP_COSINE)
				x = x + k_half_pi;
			// single 2pi wrap only
			if (x < -k_pi)
				x = x + k_two_pi;
			else if (x > k_pi)
				x = x - k_two_pi;
			if (x > x_lim) x = x_lim;
			if (x < -x_lim) x = -x_lim;

			ax = (x < 0) ? -x : x;
			p = round_q(x * ax, WORK_BITS);
			y = round_q(k_fop * x - k_fop_sq * p, WORK_BITS);
			if (y > y_lim) y = y_lim;
			if (y < -y_lim) y = -y_lim;

			ay = (y < 0) ? -y : y;
			z = round_q(y * ay, WORK_BITS);
			f = y + round_q(k_refine * (z - y), WORK_BITS);

			r = round_q(f, WORK_BITS - RESULT_FRAC);
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			return r[VALUE_W-1:0];
		endfunction

		function void note_request(logic op, logic signed [ANGLE_W-1:0] ang);
			sine_cosine_expect_t e;
			e.op = op;
			e.ang = ang;
			e.value = approx_value(op, ang);
			if (op == OP_COSINE) cosines++;
			else sines++;
			expected_q.push_back(e);
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] %s", $time, msg);
		endfunction

		function void check_result(logic signed [VALUE_W-1:0] got);
			sine_cosine_expect_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result value %0d", got));
				return;
			end
			e = expected_q.pop_front();
			checked++;
			if (got === 16'sd32767) saturated++;
			if (got !== e.value)
				report($sformatf("value mismatch: op %0d angle %0d expected %0d got %0d",
					e.op, e.ang, e.value, got));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void close_out();
			if (expected_q.size() != 0)
				report($sformatf("%0d results never arrived", expected_q.size()));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic opcode;
	logic signed [ANGLE_W-1:0] angle;
	logic out_valid;
	logic out_ready;
	logic signed [VALUE_W-1:0] value;

	sine_cosine_scoreboard sb;
	bit hold_output = 1'b0;
	int sink_count = 0;
	int idle_cycles = 0;

	// pi = 25736, pi/2 = 12868, 3pi/2 = 38604 in Q13
	int directed_angle[NUM_DIRECTED] = '{
		0, 0, 12868, -12868, 25735, 25736, -25735, -25736,
		12867, 12868, -38604, -38605, 131071, -131072, 131071, -131072,
		77208, -77208, -12868, 1, -1
	};
	logic directed_op[NUM_DIRECTED] = '{
		OP_SINE, OP_COSINE, OP_SINE, OP_SINE, OP_SINE, OP_SINE, OP_SINE, OP_SINE,
		OP_COSINE, OP_COSINE, OP_COSINE, OP_COSINE, OP_SINE, OP_SINE, OP_COSINE,
		OP_COSINE, OP_SINE, OP_SINE, OP_COSINE, OP_SINE, OP_SINE
	};

	parabolic_sine_cosine_core #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC),
		.RESULT_FRAC_BITS(RESULT_FRAC)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.angle(angle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Monitors and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(opcode, angle);
			if (out_valid && out_ready)
				sb.check_result(value);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic send_request(input logic op, input logic signed [ANGLE_W-1:0] ang,
			input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		angle <= ang;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic signed [ANGLE_W-1:0] random_angle();
		int pick;
		int base;
		pick = $urandom_range(0, 9);
		if (pick < 8)
			return ANGLE_W'(int'($urandom_range(0, 154416)) - 77208);
		if (pick == 8) begin
			// near the wrap points and the peaks
			case ($urandom_range(0, 5))
				0: base = 25736;
				1: base = -25736;
				2: base = 12868;
				3: base = -12868;
				4: base = 38604;
				default: base = -38604;
			endcase
			return ANGLE_W'(base + int'($urandom_range(0, 8)) - 4);
		end
		return ANGLE_W'($urandom());
	endfunction

	// Result sink: random back-pressure, one long hold, quiet stretches
	initial begin : result_sink
		int wait_cycles;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_output) begin
				hold_output = 1'b0;
				wait_cycles = LONG_HOLD;
			end else if (((sink_count / 300) % 3) == 2)
				wait_cycles = 0;
			else
				wait_cycles = $urandom_range(0, 5);
			if (wait_cycles > 0) begin
				out_ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sink_count++;
		end
	end

	initial begin : stimulus
		int gap;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_SINE;
		angle = '0;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < NUM_DIRECTED; k++)
			send_request(directed_op[k], ANGLE_W'(directed_angle[k]),
				$urandom_range(0, 5));
		pause_until_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// back-to-back requests while the sink holds off
			if (i == 250) hold_output = 1'b1;
			if (i == 1000) pause_until_drained();
			gap = (((i / 250) % 3) == 1) ? 0 : $urandom_range(0, 5);
			send_request(1'($urandom_range(0, 1)), random_angle(), gap);
		end

		pause_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.close_out();

		$display("covered %0d requests (%0d sine, %0d cosine), %0d results checked,",
			sb.sines + sb.cosines, sb.sines, sb.cosines, sb.checked);
		$display("%0d saturated at +1.0, with wraps, far-out angles and a full-pipe stall",
			sb.saturated);
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[parabolic_sine_cosine_core.f]
+incdir+rtl/core
rtl/core/psc_pkg.sv
rtl/core/psc_pipe_ctrl.sv
rtl/core/parabolic_sine_cosine_core.sv
test/parabolic_sine_cosine_core_tb.sv
